// ===== src/sdbt_pkg.sv =====
// package: types, constants and codes of the sparse disk block translator
package sdbt_pkg;

  localparam int unsigned TableDepth = 4096;
  localparam int unsigned IdxW       = 12;
  localparam int unsigned MaxRequest = 16384;
  localparam int unsigned MinBlock   = 512;

  localparam logic [31:0] EntryFree = 32'hffff_ffff;
  localparam logic [31:0] EntryZero = 32'hffff_fffe;

  typedef enum logic [2:0] {
    RegDiskSize   = 3'd0,
    RegBlockSize  = 3'd1,
    RegExtraSize  = 3'd2,
    RegDataOffset = 3'd3,
    RegBlockCount = 3'd4
  } reg_idx_e;

  typedef enum logic {
    OpTableWrite = 1'b0,
    OpRead       = 1'b1
  } opcode_e;

  typedef enum logic [3:0] {
    StIdle,
    StDiv,
    StLook,
    StRead,
    StMul,
    StEmit,
    StNext,
    StEmpty
  } state_e;

  typedef struct packed {
    logic        opcode;
    logic [11:0] table_index;
    logic [31:0] table_value;
    logic [47:0] byte_position;
    logic [14:0] byte_count;
  } req_t;

  typedef struct packed {
    logic [57:0] source_address;
    logic [14:0] chunk_length;
    logic        zero_fill;
    logic        last_chunk;
  } rsp_t;

endpackage

// ===== src/sparse_disk_block_translate_top.sv =====
// top level: block map translation of sparse disk reads into file chunks
//
//  channel | ports                               | handshake
//  request | start_i, req_i                      | accepted when start_i & !busy_o
//  result  | rsp_valid_o, rsp_o                  | one cycle strobe, no stall
//  config  | cfg_we_i, cfg_idx_i, cfg_data_i     | written when cfg_we_i
//
// a table write goes straight into the map and leaves the block idle. a
// read first runs the bit-serial divide of the start position by block
// size, then per chunk a map lookup, a bit-serial multiply of entry by
// stride, an emit state and, between chunks, a step state. each result
// shows in the cycle after its emit state. an empty read passes only
// through the empty state. reset clears control and config registers; the map is
// not cleared. results cannot be stalled by the receiver.
module sparse_disk_block_translate_top
  import sdbt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  req_t        req_i,
  output logic        busy_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [47:0] cfg_data_i,
  output logic        rsp_valid_o,
  output rsp_t        rsp_o
);

  logic [47:0] disk_size_q;
  logic [24:0] block_size_q;
  logic [20:0] extra_size_q;
  logic [31:0] data_offset_q;
  logic [12:0] block_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      disk_size_q   <= 48'd1;
      block_size_q  <= 25'd1048576;
      extra_size_q  <= '0;
      data_offset_q <= '0;
      block_count_q <= 13'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegDiskSize:   disk_size_q   <= cfg_data_i;
        RegBlockSize:  block_size_q  <= cfg_data_i[24:0];
        RegExtraSize:  extra_size_q  <= cfg_data_i[20:0];
        RegDataOffset: data_offset_q <= cfg_data_i[31:0];
        RegBlockCount: block_count_q <= cfg_data_i[12:0];
        default: ;
      endcase
    end
  end

  logic [24:0] bs;
  logic [12:0] nblk;
  logic [25:0] stride;
  assign bs     = (block_size_q < 25'(MinBlock)) ? 25'(MinBlock) : block_size_q;
  assign nblk   = (block_count_q > 13'(TableDepth)) ? 13'(TableDepth) : block_count_q;
  assign stride = {1'b0, bs} + 26'(extra_size_q);

  // block map memory
  logic [31:0] map_mem [TableDepth];
  logic [31:0] map_rd_q;
  logic [IdxW-1:0] map_addr;
  logic        map_we;

  state_e state_q, state_d;
  logic [47:0] quo_q, quo_d;     // dividend shifts out, quotient shifts in
  logic [25:0] rem_q, rem_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [14:0] want_q, want_d;   // bytes still to deliver
  logic [31:0] mplier_q, mplier_d;
  logic [57:0] prod_q, prod_d;
  logic [57:0] mcand_q, mcand_d;
  logic        zf_q, zf_d;
  logic [14:0] len_q, len_d;
  logic        valid_q, valid_d;
  rsp_t        rsp_q, rsp_d;

  assign map_we   = (state_q == StIdle) && start_i && (req_i.opcode == OpTableWrite);
  assign map_addr = map_we ? req_i.table_index : quo_q[IdxW-1:0];

  always_ff @(posedge clk_i) begin
    if (map_we) map_mem[map_addr] <= req_i.table_value;
    map_rd_q <= map_mem[map_addr];
  end

  logic [26:0] rem_sh;
  logic [47:0] left;
  logic [14:0] cnt_clamp;
  logic [25:0] blk_left;

  always_comb begin
    state_d  = state_q;
    quo_d    = quo_q;
    rem_d    = rem_q;
    cnt_d    = cnt_q;
    want_d   = want_q;
    mplier_d = mplier_q;
    prod_d   = prod_q;
    mcand_d  = mcand_q;
    zf_d     = zf_q;
    len_d    = len_q;
    valid_d  = 1'b0;
    rsp_d    = rsp_q;
    rem_sh   = {rem_q, quo_q[47]};
    left     = disk_size_q - req_i.byte_position;
    cnt_clamp = (req_i.byte_count > 15'(MaxRequest)) ? 15'(MaxRequest) : req_i.byte_count;
    blk_left = {1'b0, bs} - rem_q;
    unique case (state_q)
      StIdle: begin
        if (start_i && req_i.opcode == OpRead) begin
          if (cnt_clamp == '0 || req_i.byte_position >= disk_size_q) begin
            state_d = StEmpty;
          end else begin
            want_d  = (left > 48'(cnt_clamp)) ? cnt_clamp : left[14:0];
            quo_d   = req_i.byte_position;
            rem_d   = '0;
            cnt_d   = '0;
            state_d = StDiv;
          end
        end
      end
      StDiv: begin
        // restoring divide, one quotient bit per cycle
        if (rem_sh >= {2'b0, bs}) begin
          rem_d = 26'(rem_sh - {2'b0, bs});
          quo_d = {quo_q[46:0], 1'b1};
        end else begin
          rem_d = rem_sh[25:0];
          quo_d = {quo_q[46:0], 1'b0};
        end
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'd47) state_d = StLook;
      end
      StLook: begin
        len_d = (blk_left > 26'(want_q)) ? want_q : blk_left[14:0];
        state_d = StRead;
      end
      StRead: begin
        zf_d = (quo_q >= 48'(nblk)) || map_rd_q == EntryFree || map_rd_q == EntryZero;
        mplier_d = map_rd_q;
        mcand_d  = 58'(stride);
        prod_d   = 58'(data_offset_q) + 58'(extra_size_q) + 58'(rem_q);
        cnt_d    = '0;
        state_d  = StMul;
      end
      StMul: begin
        // shift-add multiply, one multiplier bit per cycle
        if (mplier_q[0]) prod_d = prod_q + mcand_q;
        mplier_d = {1'b0, mplier_q[31:1]};
        mcand_d  = {mcand_q[56:0], 1'b0};
        cnt_d    = cnt_q + 6'd1;
        if (cnt_q == 6'd31) state_d = StEmit;
      end
      StEmit: begin
        valid_d = 1'b1;
        rsp_d.source_address = zf_q ? '0 : prod_q;
        rsp_d.chunk_length   = len_q;
        rsp_d.zero_fill      = zf_q;
        rsp_d.last_chunk     = (len_q == want_q);
        want_d = want_q - len_q;
        rem_d  = '0;
        quo_d  = quo_q + 48'd1;
        state_d = (len_q == want_q) ? StIdle : StNext;
      end
      StNext: state_d = StLook;
      StEmpty: begin
        valid_d = 1'b1;
        rsp_d   = '{source_address: '0, chunk_length: '0, zero_fill: 1'b0,
                    last_chunk: 1'b1};
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q    <= quo_d;
    rem_q    <= rem_d;
    cnt_q    <= cnt_d;
    want_q   <= want_d;
    mplier_q <= mplier_d;
    prod_q   <= prod_d;
    mcand_q  <= mcand_d;
    zf_q     <= zf_d;
    len_q    <= len_d;
    rsp_q    <= rsp_d;
  end

  assign busy_o      = (state_q != StIdle);
  assign rsp_valid_o = valid_q;
  assign rsp_o       = rsp_q;

endmodule

// ===== src/sdbt_checker.sv =====
// checker: port level properties of the translator, with its bind
module sdbt_checker
  import sdbt_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input req_t req_i,
  input logic busy_o,
  input logic rsp_valid_o,
  input rsp_t rsp_o
);

  // a read is never accepted without a busy period following
  a_read_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && req_i.opcode == OpRead |=> busy_o)
    else $error("read not followed by busy");

  // a table write produces no result
  a_write_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && req_i.opcode == OpTableWrite |=> !rsp_valid_o)
    else $error("result after table write");

  // zero-filled chunks carry address zero
  a_zf_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && rsp_o.zero_fill |-> rsp_o.source_address == '0)
    else $error("zero fill with address");

  // a last result ends the transaction
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && rsp_o.last_chunk |-> !busy_o)
    else $error("busy after last result");

endmodule

bind sparse_disk_block_translate_top sdbt_checker u_sdbt_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .req_i(req_i),
  .busy_o(busy_o), .rsp_valid_o(rsp_valid_o), .rsp_o(rsp_o)
);
